FILE: rtl/nmea_sentence_framer_checker_macros.svh
// ----------------------------------------------------------------------------
// NMEA sentence framer/checker assertion macros
// Concurrent assertion wrappers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
`define NSFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NSFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSFC_ASSERT_IMP(lbl, ante, cons, msg)
`define NSFC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/nsfc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer/checker package
// Shared types and constants.
// ----------------------------------------------------------------------------
package nsfc_pkg;

    localparam int MAX_TEXT_DEF = 128;
    localparam int LEN_W        = 8;
    localparam int CHR_W        = 8;
    localparam int S_TDATA_W    = 8;
    localparam int S_TUSER_W    = 1;
    localparam int M_TDATA_W    = 48;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_END     = 3'd1,
        ST_TOO_SHORT  = 3'd2,
        ST_NO_STAR    = 3'd3,
        ST_STAR_POS   = 3'd4,
        ST_CSUM_BAD   = 3'd5,
        ST_TALKER_BAD = 3'd6
    } t_status;

    // classified input transaction
    typedef struct packed {
        logic             restart;
        logic [CHR_W-1:0] chr;
        logic             is_dollar;
        logic             is_star;
        logic             is_comma;
        logic             is_lf;
        logic             is_cr;
        logic             hex_ok;
        logic [3:0]       hex_val;
    } t_item;

endpackage

FILE: rtl/nmea_sentence_framer_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer/checker
// Frames NMEA 0183 sentences from a byte stream and checks them.
// ----------------------------------------------------------------------------
// Slave channel: one transaction per received byte. tdata carries the byte,
// tuser[0] set means restart (clears progress, status and sentence type).
// Master channel: one result transaction per input transaction, showing the
// sentence state after that byte: done flag, status, talker and type.
// An accepted input passes through the queue and then the output register
// before its result appears on the master side. Throughput: one transaction
// per cycle unless the receiver stalls, set by the back end's tracking update.
// The front end classifies each byte into a two-entry queue; the back end
// drains it whenever the output register is empty or being taken.
// When the receiver stalls the queue fills and s_tready falls after at most
// two further transactions; nothing is lost or repeated.
// Reset (synchronous, active low) empties queue and output register and
// clears sentence progress and status, including the latched talker.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_checker #(
    parameter int MAX_TEXT = nsfc_pkg::MAX_TEXT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] byte_value
    input  logic [nsfc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] action
    input  logic [nsfc_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] sentence_done, [3:1] status_code, [11:4] talker_first,
    // [19:12] talker_second, [43:20] sentence_type, [47:44] zero
    output logic [nsfc_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import nsfc_pkg::*;

    logic  w_q_ready;
    logic  w_q_push;
    t_item w_push_item;
    logic  w_q_valid;
    logic  w_q_pop;
    t_item w_pop_item;

    nsfc_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_ready  (w_q_ready),
        .o_q_push   (w_q_push),
        .o_q_item   (w_push_item)
    );

    nsfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_push_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_pop_item)
    );

    nsfc_back #(
        .MAX_TEXT (MAX_TEXT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_pop_item),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

FILE: rtl/nsfc_front.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer/checker front end
// Accepts input transactions and classifies each character.
// ----------------------------------------------------------------------------
module nsfc_front (
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [nsfc_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [nsfc_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                          i_q_ready,
    output logic                          o_q_push,
    output nsfc_pkg::t_item               o_q_item
);
    import nsfc_pkg::*;

    localparam logic [CHR_W-1:0] CHR_DOLLAR = 8'h24;
    localparam logic [CHR_W-1:0] CHR_STAR   = 8'h2A;
    localparam logic [CHR_W-1:0] CHR_COMMA  = 8'h2C;
    localparam logic [CHR_W-1:0] CHR_LF     = 8'h0A;
    localparam logic [CHR_W-1:0] CHR_CR     = 8'h0D;

    function automatic logic [4:0] hex_decode(input logic [CHR_W-1:0] c);
        logic [4:0] res;
        res = 5'd0;
        unique case (c) inside
            [8'h30:8'h39]: res = {1'b1, 4'(c - 8'h30)};
            [8'h41:8'h46]: res = {1'b1, 4'(c - 8'h37)};
            [8'h61:8'h66]: res = {1'b1, 4'(c - 8'h57)};
            default:       res = 5'd0;
        endcase
        return res;
    endfunction

    logic [CHR_W-1:0] w_chr;
    logic [4:0]       w_hex;

    assign w_chr = i_s_tdata[CHR_W-1:0];
    assign w_hex = hex_decode(w_chr);

    assign o_s_tready = i_q_ready;
    assign o_q_push   = i_s_tvalid & i_q_ready;

    always_comb begin
        o_q_item.restart   = i_s_tuser[0];
        o_q_item.chr       = w_chr;
        o_q_item.is_dollar = (w_chr == CHR_DOLLAR);
        o_q_item.is_star   = (w_chr == CHR_STAR);
        o_q_item.is_comma  = (w_chr == CHR_COMMA);
        o_q_item.is_lf     = (w_chr == CHR_LF);
        o_q_item.is_cr     = (w_chr == CHR_CR);
        o_q_item.hex_ok    = w_hex[4];
        o_q_item.hex_val   = w_hex[3:0];
    end

endmodule

FILE: rtl/nsfc_queue.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer/checker queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
`include "nmea_sentence_framer_checker_macros.svh"

module nsfc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nsfc_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_pop,
    output nsfc_pkg::t_item o_item
);
    import nsfc_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

    `NSFC_ASSERT_IMP(a_q_count_max, 1'b1, r_count <= 2'd2, "queue count over depth")
    `NSFC_ASSERT_IMP(a_q_no_overflow, i_push, r_count != 2'd2, "push into full queue")
    `NSFC_ASSERT_IMP(a_q_no_underflow, i_pop, r_count != 2'd0, "pop from empty queue")

endmodule

FILE: rtl/nsfc_back.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer/checker back end
// Sentence tracking, checks on LF and the output register.
// ----------------------------------------------------------------------------
`include "nmea_sentence_framer_checker_macros.svh"

module nsfc_back #(
    parameter int MAX_TEXT = nsfc_pkg::MAX_TEXT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  nsfc_pkg::t_item               i_q_item,
    output logic                          o_q_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [nsfc_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import nsfc_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_TEXT);
    localparam logic [LEN_W-1:0] MIN_LEN   = LEN_W'(9);
    localparam logic [LEN_W-1:0] COMMA_POS = LEN_W'(6);
    localparam logic [LEN_W-1:0] STAR_BACK = LEN_W'(3);

    logic             r_started, n_started;
    logic             r_done, n_done;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_star, n_star;
    logic [LEN_W-1:0] r_star_pos, n_star_pos;
    logic             r_comma, n_comma;
    logic [LEN_W-1:0] r_comma_pos, n_comma_pos;
    logic [7:0]       r_xor, n_xor;
    t_status          r_err, n_err;
    logic [15:0]      r_talker, n_talker;
    logic [23:0]      r_type, n_type;
    logic [CHR_W-1:0] r_head [5];
    logic [4:0]       r_tail1;
    logic [4:0]       r_tail2;

    logic             r_out_valid;
    logic             r_out_done;
    t_status          r_out_err;
    logic [15:0]      r_out_talker;
    logic [23:0]      r_out_type;

    logic             w_take;
    logic             w_lf_hit;
    logic             w_full_hit;
    logic             w_live;
    logic [7:0]       w_csum;

    assign o_q_pop = i_q_valid & (~r_out_valid | i_m_tready);

    assign w_live     = o_q_pop & ~i_q_item.restart & ~r_done;
    assign w_take     = w_live & ((r_started & (r_len < MAX_LEN) & ~i_q_item.is_lf
                                   & ~i_q_item.is_cr) | (~r_started & i_q_item.is_dollar));
    assign w_lf_hit   = w_live & r_started & (r_len < MAX_LEN) & i_q_item.is_lf;
    assign w_full_hit = w_live & r_started & (r_len >= MAX_LEN);

    // hex value of the last two characters; a non-hex digit ends it
    always_comb begin
        w_csum = 8'd0;
        if (r_tail1[4]) begin
            w_csum = r_tail2[4] ? {r_tail1[3:0], r_tail2[3:0]} : {4'd0, r_tail1[3:0]};
        end
    end

    always_comb begin
        n_started   = r_started;
        n_done      = r_done;
        n_len       = r_len;
        n_star      = r_star;
        n_star_pos  = r_star_pos;
        n_comma     = r_comma;
        n_comma_pos = r_comma_pos;
        n_xor       = r_xor;
        n_err       = r_err;
        n_talker    = r_talker;
        n_type      = r_type;
        if (o_q_pop && i_q_item.restart) begin
            n_started   = 1'b0;
            n_done      = 1'b0;
            n_len       = '0;
            n_star      = 1'b0;
            n_star_pos  = '0;
            n_comma     = 1'b0;
            n_comma_pos = '0;
            n_xor       = 8'd0;
            n_err       = ST_OK;
            n_type      = 24'd0;
        end
        if (w_full_hit) n_err = ST_NO_END;
        if (w_take) begin
            n_started = 1'b1;
            n_len     = r_len + LEN_W'(1);
            if (i_q_item.is_star && !r_star) begin
                n_star     = 1'b1;
                n_star_pos = r_len;
            end else if (!r_star && (r_len != '0)) begin
                n_xor = r_xor ^ i_q_item.chr;
            end
            if (i_q_item.is_comma && !r_comma) begin
                n_comma     = 1'b1;
                n_comma_pos = r_len;
            end
        end
        if (w_lf_hit) begin
            n_done = 1'b1;
            if (r_len < MIN_LEN) begin
                n_err = ST_TOO_SHORT;
            end else if (!r_star) begin
                n_err = ST_NO_STAR;
            end else if (r_star_pos != r_len - STAR_BACK) begin
                n_err = ST_STAR_POS;
            end else if (r_xor != w_csum) begin
                n_err = ST_CSUM_BAD;
            end else if (!r_comma || (r_comma_pos != COMMA_POS)) begin
                n_err = ST_TALKER_BAD;
            end else begin
                n_talker = {r_head[0], r_head[1]};
                n_type   = {r_head[2], r_head[3], r_head[4]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_done      <= 1'b0;
            r_len       <= '0;
            r_star      <= 1'b0;
            r_star_pos  <= '0;
            r_comma     <= 1'b0;
            r_comma_pos <= '0;
            r_xor       <= 8'd0;
            r_err       <= ST_OK;
            r_talker    <= 16'd0;
            r_type      <= 24'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_started   <= n_started;
            r_done      <= n_done;
            r_len       <= n_len;
            r_star      <= n_star;
            r_star_pos  <= n_star_pos;
            r_comma     <= n_comma;
            r_comma_pos <= n_comma_pos;
            r_xor       <= n_xor;
            r_err       <= n_err;
            r_talker    <= n_talker;
            r_type      <= n_type;
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int i = 0; i < 5; i++) begin
                if (r_len == LEN_W'(i + 1)) r_head[i] <= i_q_item.chr;
            end
            r_tail1 <= r_tail2;
            r_tail2 <= {i_q_item.hex_ok, i_q_item.hex_val};
        end
        if (o_q_pop) begin
            r_out_done   <= n_done;
            r_out_err    <= n_err;
            r_out_talker <= n_talker;
            r_out_type   <= n_type;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_type, r_out_talker[7:0], r_out_talker[15:8],
                         r_out_err, r_out_done};

    `NSFC_ASSERT_IMP(a_len_bound, 1'b1, r_len <= MAX_LEN, "text length over maximum")
    `NSFC_ASSERT_NXT(a_done_sticky, r_done && !(o_q_pop && i_q_item.restart), r_done,
                     "done dropped without restart")
    `NSFC_ASSERT_NXT(a_restart_clears, o_q_pop && i_q_item.restart,
                     !r_done && (r_len == '0) && (r_type == 24'd0) && (r_err == ST_OK),
                     "restart left progress behind")

endmodule
